// ===== hw/rtl/crhe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers of the context-rank Huffman encoder.
package crhe_pkg;

    localparam int MAX_CODE_BITS  = 16;
    localparam int CODE_LEN_W     = 5;
    localparam int RANK_ENTRIES   = 256;
    localparam int RANK_ADDR_W    = 16;
    localparam int RANK_DEPTH     = 65536;
    localparam int CODE_ADDR_W    = 8;
    localparam int CODE_ENTRY_W   = CODE_LEN_W + MAX_CODE_BITS;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_W    = 2;
    localparam int QUEUE_CNT_W    = 3;
    localparam logic [15:0] OUT_LIMIT_RESET = 16'hffff;

    typedef enum logic [1:0] {
        CMD_LOAD_RANK = 2'd0,
        CMD_LOAD_CODE = 2'd1,
        CMD_ENCODE    = 2'd2,
        CMD_NOP       = 2'd3
    } cmd_t;

    // Encode item as it travels down the pipeline.
    typedef struct packed {
        logic       first;
        logic       last;
        logic [7:0] sym;
        logic [7:0] mlen;
    } enc_item_t;

    // Results of one item: up to three bytes, the last one may be an error.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            fin_last;
        logic            fin_err;
    } res_entry_t;

    typedef struct packed {
        logic       valid;
        res_entry_t entry;
    } res_push_t;

    function automatic logic [MAX_CODE_BITS-1:0] bit_reverse(
        input logic [MAX_CODE_BITS-1:0] v
    );
        logic [MAX_CODE_BITS-1:0] r;
        for (int i = 0; i < MAX_CODE_BITS; i++) begin
            r[i] = v[MAX_CODE_BITS-1-i];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/crhe_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module crhe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/crhe_bit_packer.sv =====
`timescale 1ns / 1ps
// Bit packer: emits header bytes and packed code bits; applies the output limit.
module crhe_bit_packer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  crhe_pkg::enc_item_t                 item,
    input  logic [crhe_pkg::CODE_ENTRY_W-1:0]   code_rd,
    input  logic [15:0]                         out_limit,
    output crhe_pkg::res_push_t                 push
);

    logic [7:0]  buf_reg, buf_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [15:0] bw_reg, bw_next;
    logic        aborted_reg, aborted_next;

    logic [crhe_pkg::MAX_CODE_BITS-1:0] code_rev;
    logic [crhe_pkg::CODE_LEN_W-1:0]    code_len;
    logic [23:0]     w;
    logic [4:0]      total;
    logic [1:0]      nfull;
    logic [2:0]      rem;
    logic            flush;
    logic [1:0]      k;
    logic [2:0][7:0] cand;
    logic [7:0]      rem_byte;
    logic [15:0]     base_bw;
    logic [15:0]     diff;
    logic [1:0]      avail;
    logic            err;
    logic [1:0]      n_ok;
    logic            active;

    assign code_len = code_rd[crhe_pkg::CODE_ENTRY_W-1:crhe_pkg::MAX_CODE_BITS];
    assign code_rev = code_rd[crhe_pkg::MAX_CODE_BITS-1:0];

    always_comb begin
        w     = 24'(buf_reg) | (24'(code_rev) << cnt_reg);
        total = 5'(cnt_reg) + code_len;
        nfull = total[4:3];
        rem   = total[2:0];
        flush = item.last && (rem != 3'd0);

        if (item.first) begin
            k    = 2'd2;
            cand = {8'd0, item.sym, item.mlen};
        end else begin
            k    = nfull + {1'b0, flush};
            cand = {w[23:16], w[15:8], w[7:0]};
        end

        case (nfull)
            2'd0:    rem_byte = w[7:0];
            2'd1:    rem_byte = w[15:8];
            default: rem_byte = w[23:16];
        endcase

        base_bw = item.first ? 16'd0 : bw_reg;
        diff    = out_limit - base_bw;
        if (base_bw >= out_limit) begin
            avail = 2'd0;
        end else if (diff > 16'd3) begin
            avail = 2'd3;
        end else begin
            avail = diff[1:0];
        end

        err    = k > avail;
        n_ok   = err ? avail : k;
        active = in_valid && (item.first || !aborted_reg);

        push.valid          = active && ((err ? avail + 2'd1 : k) != 2'd0);
        push.entry.cnt      = err ? avail + 2'd1 : k;
        push.entry.fin_err  = err;
        push.entry.fin_last = err || item.last;
        for (int j = 0; j < 3; j++) begin
            push.entry.bytes[j] = (2'(j) < n_ok) ? cand[j] : 8'd0;
        end

        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        bw_next      = bw_reg;
        aborted_next = aborted_reg;
        if (active) begin
            bw_next      = base_bw + 16'(n_ok);
            aborted_next = err;
            if (item.first || err || flush) begin
                buf_next = 8'd0;
                cnt_next = 3'd0;
            end else begin
                buf_next = rem_byte;
                cnt_next = rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg     <= 8'd0;
            cnt_reg     <= 3'd0;
            bw_reg      <= 16'd0;
            aborted_reg <= 1'b0;
        end else begin
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            bw_reg      <= bw_next;
            aborted_reg <= aborted_next;
        end
    end

endmodule

// ===== hw/rtl/crhe_result_queue.sv =====
`timescale 1ns / 1ps
// Result queue: holds per-item result groups and drains them one byte at a time, as m_tready allows.
module crhe_result_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  crhe_pkg::res_push_t               push,
    output logic [crhe_pkg::QUEUE_CNT_W-1:0]  q_count,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);

    crhe_pkg::res_entry_t entries [crhe_pkg::QUEUE_DEPTH];

    logic [crhe_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [crhe_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [crhe_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [1:0] sub_reg, sub_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       err_reg, err_next;

    crhe_pkg::res_entry_t head;
    logic load;
    logic pop;
    logic fin;

    assign head = entries[rd_ptr_reg];
    assign fin  = (sub_reg == head.cnt - 2'd1);
    assign load = (count_reg != '0) && (!valid_reg || m_tready);
    assign pop  = load && fin;

    always_comb begin
        wr_ptr_next = push.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + crhe_pkg::QUEUE_CNT_W'(push.valid)
                      - crhe_pkg::QUEUE_CNT_W'(pop);
        sub_next    = sub_reg;
        if (load) begin
            sub_next = fin ? 2'd0 : sub_reg + 2'd1;
        end

        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        if (load) begin
            valid_next = 1'b1;
            byte_next  = head.bytes[sub_reg];
            last_next  = fin && head.fin_last;
            err_next   = fin && head.fin_err;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entries[wr_ptr_reg] <= push.entry;
        end
        byte_reg <= byte_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 2'd0;
            valid_reg  <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
            valid_reg  <= valid_next;
        end
    end

    assign q_count  = count_reg;
    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = err_reg;

endmodule

// ===== hw/rtl/context_rank_huffman_encoder.sv =====
`timescale 1ns / 1ps
// The first result of an item reaches m_ through stages 1 and 2, the result queue and its output register.
// Throughput: one item per cycle while items yield at most one result each and m_tready
//   is high; the output register sends one result per cycle, so an item's results go out in turn.
// The rank and code memories are each read once per item, the code memory in the cycle after the rank memory.
// Reset (aresetn low, synchronous): clears pipeline, queue and bit state, out_limit = 65535.
// Rank and code memories are not cleared; load entries before encoding against them.
module context_rank_huffman_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: out_limit
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] context_byte, [15:8] symbol_byte, [23:16] rank, [39:24] code_value,
    // [44:40] code_length, [52:45] msg_length, [55:53] zero
    input  logic [55:0] s_tdata,
    // [1:0] cmd, [2] first
    input  logic [2:0]  s_tuser,
    input  logic        s_tlast,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte
    output logic [7:0]  m_tdata,
    // [0] error
    output logic        m_tuser,
    output logic        m_tlast
);

    // Unpack the input item.
    logic [1:0]  in_cmd;
    logic [7:0]  in_ctx;
    logic [7:0]  in_sym;
    logic [7:0]  in_rank;
    logic [15:0] in_cval;
    logic [4:0]  in_clen;
    logic [7:0]  in_mlen;
    logic        in_first;
    logic        accept;

    assign in_cmd   = s_tuser[1:0];
    assign in_first = s_tuser[2];
    assign in_ctx   = s_tdata[7:0];
    assign in_sym   = s_tdata[15:8];
    assign in_rank  = s_tdata[23:16];
    assign in_cval  = s_tdata[39:24];
    assign in_clen  = s_tdata[44:40];
    assign in_mlen  = s_tdata[52:45];
    assign accept   = s_tvalid && s_tready;

    // Command decode.
    logic is_load_rank;
    logic is_load_code;
    logic is_encode;

    always_comb begin
        is_load_rank = 1'b0;
        is_load_code = 1'b0;
        is_encode    = 1'b0;
        unique case (crhe_pkg::cmd_t'(in_cmd))
            crhe_pkg::CMD_LOAD_RANK: is_load_rank = 1'b1;
            crhe_pkg::CMD_LOAD_CODE: is_load_code = 1'b1;
            crhe_pkg::CMD_ENCODE:    is_encode    = 1'b1;
            default: ;
        endcase
    end

    // Configuration register.
    logic [15:0] out_limit_reg, out_limit_next;

    assign out_limit_next = cfg_wr_en ? cfg_wr_data : out_limit_reg;

    // Previous byte advances on every encode item. While a message is aborted the
    // value is never used, and the next first item overwrites it.
    logic [7:0] prev_reg, prev_next;

    assign prev_next = (accept && is_encode) ? in_sym : prev_reg;

    // Store code entries bit-reversed and with the saturated length, so that the
    // packer merely shifts them into place.
    logic [crhe_pkg::CODE_LEN_W-1:0]    sat_len;
    logic [crhe_pkg::MAX_CODE_BITS-1:0] rev_code;

    always_comb begin
        if (in_clen > crhe_pkg::CODE_LEN_W'(crhe_pkg::MAX_CODE_BITS)) begin
            sat_len = crhe_pkg::CODE_LEN_W'(crhe_pkg::MAX_CODE_BITS);
        end else begin
            sat_len = in_clen;
        end
        rev_code = crhe_pkg::bit_reverse(in_cval)
                   >> (crhe_pkg::CODE_LEN_W'(crhe_pkg::MAX_CODE_BITS) - sat_len);
    end

    // Rank memory, addressed by {previous byte, symbol}.
    logic [7:0] rank_rd;

    crhe_ram #(
        .WIDTH (8),
        .DEPTH (crhe_pkg::RANK_DEPTH)
    ) u_rank_ram (
        .aclk  (aclk),
        .we    (accept && is_load_rank),
        .waddr ({in_ctx, in_sym}),
        .wdata (in_rank),
        .raddr ({prev_reg, in_sym}),
        .rdata (rank_rd)
    );

    // Stage 1: rank read data is valid.
    logic                s1_valid_reg, s1_valid_next;
    crhe_pkg::enc_item_t s1_item_reg, s1_item_next;
    // Stage 2: code read data is valid.
    logic                s2_valid_reg;
    crhe_pkg::enc_item_t s2_item_reg;

    always_comb begin
        s1_valid_next      = accept && is_encode;
        s1_item_next.first = in_first;
        s1_item_next.last  = s_tlast;
        s1_item_next.sym   = in_sym;
        s1_item_next.mlen  = in_mlen;
    end

    // Code memory, addressed by rank; a load after an encode writes at the same edge
    // the encode reads, and the read returns the older entry as required.
    logic [crhe_pkg::CODE_ENTRY_W-1:0] code_rd;

    crhe_ram #(
        .WIDTH (crhe_pkg::CODE_ENTRY_W),
        .DEPTH (crhe_pkg::RANK_ENTRIES)
    ) u_code_ram (
        .aclk  (aclk),
        .we    (accept && is_load_code),
        .waddr (in_rank),
        .wdata ({sat_len, rev_code}),
        .raddr (rank_rd),
        .rdata (code_rd)
    );

    crhe_pkg::res_push_t push;

    crhe_bit_packer u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid_reg),
        .item      (s2_item_reg),
        .code_rd   (code_rd),
        .out_limit (out_limit_reg),
        .push      (push)
    );

    logic [crhe_pkg::QUEUE_CNT_W-1:0] q_count;

    crhe_result_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .q_count  (q_count),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Every item in flight holds a claim on one queue slot; accept only while a
    // slot is left for one more.
    logic [crhe_pkg::QUEUE_CNT_W-1:0] claims;

    assign claims   = q_count + crhe_pkg::QUEUE_CNT_W'(s1_valid_reg)
                      + crhe_pkg::QUEUE_CNT_W'(s2_valid_reg);
    assign s_tready = claims < crhe_pkg::QUEUE_CNT_W'(crhe_pkg::QUEUE_DEPTH);

    always_ff @(posedge aclk) begin
        s1_item_reg <= s1_item_next;
        s2_item_reg <= s1_item_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_limit_reg <= crhe_pkg::OUT_LIMIT_RESET;
            prev_reg      <= 8'd0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end else begin
            out_limit_reg <= out_limit_next;
            prev_reg      <= prev_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
        end
    end

endmodule
